>>> rtl/overwrite_oldest_record_fifo_unit_defines.svh
// Assertion macros used by the record FIFO ring control (oorf_ctrl).
// Each macro expects clk and rst_n to be visible in the using scope.
`ifndef OVERWRITE_OLDEST_RECORD_FIFO_UNIT_DEFINES_SVH
`define OVERWRITE_OLDEST_RECORD_FIFO_UNIT_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define OORF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("oorf assertion failed");

// Check that a trigger implies a consequence in the next cycle.
`define OORF_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("oorf assertion failed");

`endif

>>> rtl/oorf_pkg.sv
// Package for the overwrite-oldest record FIFO: record type, action codes,
// status struct and default sizes. No dependencies.
package oorf_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int HELD_W    = 4;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [31:0] timestamp;
    logic [31:0] voltage;
    logic [31:0] current;
    logic [31:0] temperature;
    logic [31:0] accel_magnitude;
    logic [31:0] gyro_magnitude;
    logic [7:0]  fault_bits;
    logic [7:0]  mode_code;
  } record_t;

  localparam int REC_W = $bits(record_t);

  // Per-transfer status from the pointer control to the result stage
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              rec_valid;
    logic              overflow;
    logic [HELD_W-1:0] held_count;
  } ctrl_stat_t;

endpackage

>>> rtl/oorf_in_if.sv
// Input channel of the record FIFO: valid/ready handshake with one item.
// Depends on nothing.
interface oorf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] in_timestamp;
  logic [31:0] in_voltage;
  logic [31:0] in_current;
  logic [31:0] in_temperature;
  logic [31:0] in_accel_magnitude;
  logic [31:0] in_gyro_magnitude;
  logic [7:0]  in_fault_bits;
  logic [7:0]  in_mode_code;

  modport source (
    output valid, action, in_timestamp, in_voltage, in_current, in_temperature,
           in_accel_magnitude, in_gyro_magnitude, in_fault_bits, in_mode_code,
    input  ready
  );
  modport sink (
    input  valid, action, in_timestamp, in_voltage, in_current, in_temperature,
           in_accel_magnitude, in_gyro_magnitude, in_fault_bits, in_mode_code,
    output ready
  );
endinterface

>>> rtl/oorf_out_if.sv
// Result channel of the record FIFO: valid/ready handshake with one result.
// Depends on nothing.
interface oorf_out_if;
  logic        valid;
  logic        ready;
  logic        record_valid;
  logic [31:0] out_timestamp;
  logic [31:0] out_voltage;
  logic [31:0] out_current;
  logic [31:0] out_temperature;
  logic [31:0] out_accel_magnitude;
  logic [31:0] out_gyro_magnitude;
  logic [7:0]  out_fault_bits;
  logic [7:0]  out_mode_code;
  logic [3:0]  held_count;
  logic        overflow_seen;

  modport source (
    output valid, record_valid, out_timestamp, out_voltage, out_current,
           out_temperature, out_accel_magnitude, out_gyro_magnitude,
           out_fault_bits, out_mode_code, held_count, overflow_seen,
    input  ready
  );
  modport sink (
    input  valid, record_valid, out_timestamp, out_voltage, out_current,
           out_temperature, out_accel_magnitude, out_gyro_magnitude,
           out_fault_bits, out_mode_code, held_count, overflow_seen,
    output ready
  );
endinterface

>>> rtl/oorf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
module oorf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write the slot and register the read word; hold it when not reading
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/oorf_ctrl.sv
// Head/tail/count/overflow control of the record FIFO ring.
// Depends on oorf_pkg and the assertion macro header.
`include "overwrite_oldest_record_fifo_unit_defines.svh"

module oorf_ctrl #(
  parameter int SLOTS = oorf_pkg::SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [1:0]          action,
  output logic [IDX_W-1:0]    wr_addr,
  output logic [IDX_W-1:0]    rd_addr,
  output oorf_pkg::ctrl_stat_t stat
);
  import oorf_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(SLOTS);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic             flag_r, flag_nxt;
  logic [IDX_W-1:0] head_inc, tail_inc;
  logic             full;
  logic [IDX_W:0]   ptr_gap;

  // Wrap the pointers at the last slot
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign full     = (head_inc == tail_r);

  // Work out the next pointer state and the status of this transfer
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    flag_nxt        = flag_r;
    stat.wr_en      = 1'b0;
    stat.rd_en      = 1'b0;
    stat.rec_valid  = 1'b0;
    case (action)
      ACT_PUSH: begin
        stat.wr_en = fire;
        head_nxt   = head_inc;
        if (full) begin
          flag_nxt = 1'b1;
          tail_nxt = tail_inc;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_POP: begin
        if (count_r != '0) begin
          stat.rd_en     = fire;
          stat.rec_valid = 1'b1;
          tail_nxt       = tail_inc;
          count_nxt      = count_r - 1'b1;
        end
      end
      ACT_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
        flag_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
    stat.overflow   = flag_nxt;
    stat.held_count = HELD_W'(count_nxt);
  end

  assign wr_addr = head_r;
  assign rd_addr = tail_r;

  // Advance the ring state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      flag_r  <= 1'b0;
    end else if (fire) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // Distance from tail to head, modulo the ring size
  assign ptr_gap = (head_r >= tail_r) ?
                   ({1'b0, head_r} - {1'b0, tail_r}) :
                   ({1'b0, head_r} + SLOTS_X - {1'b0, tail_r});

  `OORF_ASSERT_ALWAYS(a_count_matches_ptrs, ptr_gap == {1'b0, count_r})
  `OORF_ASSERT_ALWAYS(a_no_pop_when_empty, !(stat.rd_en && (count_r == '0)))
  `OORF_ASSERT_NEXT(a_full_push_keeps_count,
                    fire && (action == ACT_PUSH) && full, $stable(count_r) && flag_r)
  `OORF_ASSERT_NEXT(a_clear_empties, fire && (action == ACT_CLEAR),
                    (count_r == '0) && !flag_r && (head_r == tail_r))

endmodule

>>> rtl/overwrite_oldest_record_fifo_unit.sv
// Top level of the overwrite-oldest record FIFO: input stage, ring control,
// record RAM and result register. Depends on oorf_pkg, the channel
// interfaces, oorf_ctrl and oorf_ram.
//
//   channel  modport  carries
//   in_ch    sink     action plus one telemetry record (push payload)
//   out_ch   source   record_valid, popped record, held_count, overflow_seen
//
// One item per cycle while the result is not stalled; a result passes
// the input register, then the RAM read and result register. The pointer
// update and slot access happen in the RAM read step.
// Reset (synchronous, rst_n low) empties the ring and drops the overflow
// flag; record slots are not cleared. A stalled result holds and the input
// register fills behind it, then in_ch.ready drops.
module overwrite_oldest_record_fifo_unit #(
  parameter int SLOTS = oorf_pkg::SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  oorf_in_if.sink   in_ch,
  oorf_out_if.source out_ch
);
  import oorf_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic             s1_valid_r;
  logic [1:0]       s1_action_r;
  record_t          s1_rec_r;
  logic             out_valid_r;
  ctrl_stat_t       stat;
  ctrl_stat_t       stat_r;
  logic             s1_fire;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  record_t          rd_rec;
  logic [REC_W-1:0] rd_data;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      s1_action_r              <= in_ch.action;
      s1_rec_r.timestamp       <= in_ch.in_timestamp;
      s1_rec_r.voltage         <= in_ch.in_voltage;
      s1_rec_r.current         <= in_ch.in_current;
      s1_rec_r.temperature     <= in_ch.in_temperature;
      s1_rec_r.accel_magnitude <= in_ch.in_accel_magnitude;
      s1_rec_r.gyro_magnitude  <= in_ch.in_gyro_magnitude;
      s1_rec_r.fault_bits      <= in_ch.in_fault_bits;
      s1_rec_r.mode_code       <= in_ch.in_mode_code;
    end
  end

  oorf_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .action  (s1_action_r),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .stat    (stat)
  );

  oorf_ram #(
    .WIDTH  (REC_W),
    .DEPTH  (SLOTS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (stat.wr_en),
    .wr_addr (wr_addr),
    .wr_data (s1_rec_r),
    .rd_en   (stat.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the result status until the transfer out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
    if (s1_fire) begin
      stat_r <= stat;
    end
  end

  // Zero the record fields unless a pop returned a record
  assign rd_rec = stat_r.rec_valid ? record_t'(rd_data) : '0;

  assign out_ch.valid               = out_valid_r;
  assign out_ch.record_valid        = stat_r.rec_valid;
  assign out_ch.out_timestamp       = rd_rec.timestamp;
  assign out_ch.out_voltage         = rd_rec.voltage;
  assign out_ch.out_current         = rd_rec.current;
  assign out_ch.out_temperature     = rd_rec.temperature;
  assign out_ch.out_accel_magnitude = rd_rec.accel_magnitude;
  assign out_ch.out_gyro_magnitude  = rd_rec.gyro_magnitude;
  assign out_ch.out_fault_bits      = rd_rec.fault_bits;
  assign out_ch.out_mode_code       = rd_rec.mode_code;
  assign out_ch.held_count          = stat_r.held_count;
  assign out_ch.overflow_seen       = stat_r.overflow;

endmodule

>>> test/overwrite_oldest_record_fifo_unit_test.sv
// Testbench for overwrite_oldest_record_fifo_unit: random and directed push/pop/clear traffic,
// each result checked field by field against a ring predictor kept in the bench.
// Depends on oorf_pkg, oorf_in_if, oorf_out_if and the RTL top level.
`timescale 1ns / 1ps

module overwrite_oldest_record_fifo_unit_test;
  import oorf_pkg::*;

  localparam int SLOTS         = SLOTS_DEF;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_EVERY   = 300;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic              rec_valid;
    record_t           rec;
    logic [HELD_W-1:0] held;
    logic              ovf;
  } fifo_result_t;

  typedef struct {
    logic [1:0] action;
    record_t    rec;
    int         gap;
    bit         drain;
  } stim_item_t;

  logic clk;
  logic rst_n;

  oorf_in_if  in_ch ();
  oorf_out_if out_ch ();

  overwrite_oldest_record_fifo_unit #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Ring predictor state
  record_t ring_slots [SLOTS];
  int      ring_head;
  int      ring_tail;
  int      ring_count;
  logic    ring_overflow;

  stim_item_t   stimulus_items [$];
  fifo_result_t expected_results [$];
  stim_item_t   cur_item;
  fifo_result_t want_res;
  fifo_result_t got_res;
  bit           in_taken;
  int           mismatch_count;
  int           cycle_count;
  int           stall_left;
  int           stall_mode;

  // Apply one transfer to the ring and return the result it produces
  function automatic fifo_result_t predict_ring_result(logic [1:0] act, record_t rec);
    fifo_result_t res;
    int           next_head;
    res = '0;
    case (act)
      ACT_PUSH: begin
        next_head = (ring_head + 1) % SLOTS;
        // Full ring: drop the oldest record and latch overflow
        if (next_head == ring_tail) begin
          ring_overflow = 1'b1;
          ring_tail     = (ring_tail + 1) % SLOTS;
        end else begin
          ring_count++;
        end
        ring_slots[ring_head] = rec;
        ring_head             = next_head;
      end
      ACT_POP: begin
        if (ring_count > 0) begin
          res.rec_valid = 1'b1;
          res.rec       = ring_slots[ring_tail];
          ring_tail     = (ring_tail + 1) % SLOTS;
          ring_count--;
        end
      end
      ACT_CLEAR: begin
        ring_head     = 0;
        ring_tail     = 0;
        ring_count    = 0;
        ring_overflow = 1'b0;
      end
      default: ;
    endcase
    res.held = HELD_W'(ring_count);
    res.ovf  = ring_overflow;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %08h, got %08h", name, want, got);
    end
  endtask

  // Extremes show up often, plain random words otherwise
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic record_t rand_record();
    record_t rec;
    rec.timestamp       = rand_word();
    rec.voltage         = rand_word();
    rec.current         = rand_word();
    rec.temperature     = rand_word();
    rec.accel_magnitude = rand_word();
    rec.gyro_magnitude  = rand_word();
    rec.fault_bits      = 8'(rand_word());
    rec.mode_code       = 8'(rand_word());
    return rec;
  endfunction

  // Gap before an item: none, or mostly none with some short and a few long ones
  function automatic int pick_gap(int gap_mode);
    int roll;
    if (gap_mode == 0)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 75)
      return 0;
    if (roll < 96)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_item(input logic [1:0] act, input record_t rec, input int gap,
                          input bit drain);
    stim_item_t item;
    item.action = act;
    item.rec    = rec;
    item.gap    = gap;
    item.drain  = drain;
    stimulus_items.push_back(item);
  endtask

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Input driver: present the next pending item once the previous one transferred
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (stimulus_items.size() == 0 || stimulus_items[0].gap > 0 ||
          (stimulus_items[0].drain && expected_results.size() != 0)) begin
        if (stimulus_items.size() != 0 && stimulus_items[0].gap > 0)
          stimulus_items[0].gap = stimulus_items[0].gap - 1;
        in_ch.valid <= 1'b0;
      end else begin
        cur_item = stimulus_items.pop_front();
        in_ch.valid              <= 1'b1;
        in_ch.action             <= cur_item.action;
        in_ch.in_timestamp       <= cur_item.rec.timestamp;
        in_ch.in_voltage         <= cur_item.rec.voltage;
        in_ch.in_current         <= cur_item.rec.current;
        in_ch.in_temperature     <= cur_item.rec.temperature;
        in_ch.in_accel_magnitude <= cur_item.rec.accel_magnitude;
        in_ch.in_gyro_magnitude  <= cur_item.rec.gyro_magnitude;
        in_ch.in_fault_bits      <= cur_item.rec.fault_bits;
        in_ch.in_mode_code       <= cur_item.rec.mode_code;
      end
    end
    in_taken = 1'b0;
  end

  // Result ready: always-ready, short stalls or long stalls, mode switches now and then
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      case (stall_mode)
        1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
        2: if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(8, 40);
        default: ;
      endcase
    end
    if ($urandom_range(0, 199) == 0)
      stall_mode = $urandom_range(0, 2);
  end

  // Monitor: check the result transfer first, then predict the input transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_res.rec_valid           = out_ch.record_valid;
        got_res.rec.timestamp       = out_ch.out_timestamp;
        got_res.rec.voltage         = out_ch.out_voltage;
        got_res.rec.current         = out_ch.out_current;
        got_res.rec.temperature     = out_ch.out_temperature;
        got_res.rec.accel_magnitude = out_ch.out_accel_magnitude;
        got_res.rec.gyro_magnitude  = out_ch.out_gyro_magnitude;
        got_res.rec.fault_bits      = out_ch.out_fault_bits;
        got_res.rec.mode_code       = out_ch.out_mode_code;
        got_res.held                = out_ch.held_count;
        got_res.ovf                 = out_ch.overflow_seen;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result transfer with no expected result pending");
        end else begin
          want_res = expected_results.pop_front();
          check_field("record_valid", 32'(want_res.rec_valid), 32'(got_res.rec_valid));
          check_field("timestamp", want_res.rec.timestamp, got_res.rec.timestamp);
          check_field("voltage", want_res.rec.voltage, got_res.rec.voltage);
          check_field("current", want_res.rec.current, got_res.rec.current);
          check_field("temperature", want_res.rec.temperature, got_res.rec.temperature);
          check_field("accel_magnitude", want_res.rec.accel_magnitude,
                      got_res.rec.accel_magnitude);
          check_field("gyro_magnitude", want_res.rec.gyro_magnitude,
                      got_res.rec.gyro_magnitude);
          check_field("fault_bits", 32'(want_res.rec.fault_bits),
                      32'(got_res.rec.fault_bits));
          check_field("mode_code", 32'(want_res.rec.mode_code), 32'(got_res.rec.mode_code));
          check_field("held_count", 32'(want_res.held), 32'(got_res.held));
          check_field("overflow_seen", 32'(want_res.ovf), 32'(got_res.ovf));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cur_item.rec.timestamp       = in_ch.in_timestamp;
        cur_item.rec.voltage         = in_ch.in_voltage;
        cur_item.rec.current         = in_ch.in_current;
        cur_item.rec.temperature     = in_ch.in_temperature;
        cur_item.rec.accel_magnitude = in_ch.in_accel_magnitude;
        cur_item.rec.gyro_magnitude  = in_ch.in_gyro_magnitude;
        cur_item.rec.fault_bits      = in_ch.in_fault_bits;
        cur_item.rec.mode_code       = in_ch.in_mode_code;
        expected_results.push_back(predict_ring_result(in_ch.action, cur_item.rec));
        in_taken = 1'b1;
      end
    end
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int      item_total;
    int      burst_len;
    int      kind;
    int      gap_mode;
    int      next_drain;
    bit      drain_now;
    record_t rec_zero;
    record_t rec_ones;
    logic [1:0] act;

    clk            = 1'b0;
    rst_n          = 1'b0;
    in_taken       = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    stall_left     = 0;
    stall_mode     = 0;
    ring_head      = 0;
    ring_tail      = 0;
    ring_count     = 0;
    ring_overflow  = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.action             = ACT_PUSH;
    in_ch.in_timestamp       = '0;
    in_ch.in_voltage         = '0;
    in_ch.in_current         = '0;
    in_ch.in_temperature     = '0;
    in_ch.in_accel_magnitude = '0;
    in_ch.in_gyro_magnitude  = '0;
    in_ch.in_fault_bits      = '0;
    in_ch.in_mode_code       = '0;
    out_ch.ready             = 1'b0;
    rec_zero = '0;
    rec_ones = '1;

    // Directed: empty pop, unused code, extreme records, fill past full, clear
    add_item(ACT_POP, rand_record(), 0, 1'b0);
    add_item(ACT_UNUSED, rand_record(), 0, 1'b0);
    add_item(ACT_PUSH, rec_zero, 0, 1'b0);
    add_item(ACT_PUSH, rec_ones, 1, 1'b0);
    add_item(ACT_POP, rand_record(), 0, 1'b0);
    add_item(ACT_POP, rand_record(), 0, 1'b0);
    for (int i = 0; i < SLOTS; i++)
      add_item(ACT_PUSH, rand_record(), 0, 1'b0);
    add_item(ACT_POP, rand_record(), 0, 1'b0);
    add_item(ACT_CLEAR, rand_record(), 0, 1'b0);
    add_item(ACT_POP, rand_record(), 0, 1'b0);

    // Random bursts: fills, drains, mixed traffic, occasional clears
    item_total = 0;
    next_drain = DRAIN_EVERY;
    drain_now  = 1'b1;
    while (item_total < RANDOM_ITEMS) begin
      gap_mode = $urandom_range(0, 2);
      kind     = $urandom_range(0, 9);
      if (kind <= 3)
        burst_len = $urandom_range(1, 20);
      else if (kind <= 6)
        burst_len = $urandom_range(1, 18);
      else if (kind <= 8)
        burst_len = $urandom_range(10, 40);
      else
        burst_len = 1;
      for (int i = 0; i < burst_len; i++) begin
        if (kind <= 3)
          act = ACT_PUSH;
        else if (kind <= 6)
          act = ACT_POP;
        else if (kind <= 8)
          act = ($urandom_range(0, 99) < 65) ? ACT_PUSH : ACT_POP;
        else
          act = ($urandom_range(0, 4) == 0) ? ACT_UNUSED : ACT_CLEAR;
        add_item(act, rand_record(), pick_gap(gap_mode), drain_now);
        drain_now = 1'b0;
        if (act != ACT_UNUSED)
          item_total++;
        // Hold the sender until the pipeline has drained, now and then
        if (item_total >= next_drain) begin
          drain_now  = 1'b1;
          next_drain = next_drain + DRAIN_EVERY;
        end
      end
    end

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    while (stimulus_items.size() != 0 || in_ch.valid)
      @(posedge clk);
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/oorf_pkg.sv
rtl/oorf_in_if.sv
rtl/oorf_out_if.sv
rtl/oorf_ram.sv
rtl/oorf_ctrl.sv
rtl/overwrite_oldest_record_fifo_unit.sv
test/overwrite_oldest_record_fifo_unit_test.sv
